// File: hdl/ach_pkg.sv
// Package for the anchor consistent hash block: sizes, codes, request and
// result types, sequencer states and the mixer helpers.
// No dependencies.
package ach_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = 10;
    localparam int CNT_W    = 11;

    localparam logic [31:0] MIX_SEED = 32'hf1ea5eed;
    localparam int          MIX_ROT1 = 27;
    localparam int          MIX_ROT2 = 17;
    localparam int          MIX_INIT_ROUNDS = 3;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_RANGE    = 2'd1;
    localparam logic [1:0] STAT_NO_FREE  = 2'd2;
    localparam logic [1:0] STAT_INACTIVE = 2'd3;

    localparam logic REG_TOTAL   = 1'b0;
    localparam logic REG_WORKING = 1'b1;

    typedef struct packed {
        logic [1:0]       func;
        logic [63:0]      key;
        logic [IDX_W-1:0] inst_id;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] instance_res;
        logic [IDX_W-1:0] bucket;
        logic [1:0]       status;
    } res_t;

    typedef struct packed {
        logic load;
        logic step;
    } mix_ctrl_t;

    typedef struct packed {
        logic             start;
        logic [31:0]      dividend;
        logic [CNT_W-1:0] divisor;
    } mod_ctrl_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_LK_MIX,
        ST_LK_MODGO,
        ST_LK_MOD,
        ST_LK_CHKA,
        ST_LK_STEP,
        ST_LK_RDH,
        ST_LK_CHKH,
        ST_LK_SUCC,
        ST_LK_INST,
        ST_AD_CHK,
        ST_AD_WRW,
        ST_AD_FIN,
        ST_RM_CHK,
        ST_RM_WR,
        ST_RM_RD3,
        ST_RM_WR2,
        ST_DONE
    } state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

endpackage

// File: hdl/ach_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module ach_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: hdl/ach_mixer.sv
// Four-word mixer state with one round per cycle while step is set.
// Depends on ach_pkg.
module ach_mixer (
    input  logic              clk,
    input  logic              rst_n,
    input  ach_pkg::mix_ctrl_t ctrl,
    input  logic [31:0]       seed,
    output logic [31:0]       d_out
);
    import ach_pkg::*;

    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [31:0] e;

    always_comb
    begin
        e      = a_reg - rotl(b_reg, MIX_ROT1);
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        if (ctrl.load)
        begin
            a_next = MIX_SEED;
            b_next = seed;
            c_next = seed;
            d_next = seed;
        end
        else if (ctrl.step)
        begin
            a_next = b_reg ^ rotl(c_reg, MIX_ROT2);
            b_next = c_reg + d_reg;
            c_next = d_reg + e;
            d_next = e + a_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule

// File: hdl/ach_mod.sv
// Restoring remainder unit: 32-bit dividend modulo an 11-bit divisor,
// one quotient bit per cycle.
// Depends on ach_pkg.
module ach_mod (
    input  logic               clk,
    input  logic               rst_n,
    input  ach_pkg::mod_ctrl_t ctrl,
    output logic               done,
    output logic [ach_pkg::IDX_W-1:0] rem
);
    import ach_pkg::*;

    logic [31:0]      q_reg, q_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] div_reg, div_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[31]};
        if (ctrl.start)
        begin
            q_next    = ctrl.dividend;
            rem_next  = '0;
            div_next  = ctrl.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[30:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[IDX_W-1:0];
endmodule

// File: hdl/anchor_consistent_hash.sv
// Top level of the anchor consistent hash block: APB register port,
// sequencer, anchor table memories, mixer and remainder unit.
// Depends on ach_pkg, ach_ram, ach_mixer and ach_mod.

// The block maps 64-bit keys onto a fixed pool of up to 1024 buckets and
// lets instances be added and removed without remapping the keys of other
// buckets. One request is worked at a time and req_ready is low meanwhile.
// A lookup runs through acceptance, dispatch and three mixer rounds, then
// the first remainder by the bucket count (a start, 32 remainder steps and
// a done strobe) and a check of the anchor size. Every anchor hop adds one
// mixer round, another remainder by the bucket's anchor size and one check,
// plus a successor read and an anchor read for every successor followed.
// The instance read and the result hand-off close the lookup. An add and a
// remove are paced by their dependent table reads. After reset, and after
// every write to either register, a clearing pass rewrites all 1024 entries
// of every table while no request is accepted; register writes are still
// taken. Out-of-range register values are clamped: a bucket count of 0 acts
// as 1 and one above 1024 as 1024, and the working count is limited to the
// bucket count. A result waits in an output register until it is taken.
module anchor_consistent_hash (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  ach_pkg::req_t        req,
    output logic                 res_valid,
    input  logic                 res_ready,
    output ach_pkg::res_t        res
);
    import ach_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] work_reg, work_next;
    logic [CNT_W-1:0] sc_reg, sc_next;
    logic [CNT_W-1:0] wc_reg, wc_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             first_reg, first_next;
    req_t             req_reg, req_next;
    logic [IDX_W-1:0] b_reg, b_next;
    logic [IDX_W-1:0] h_reg, h_next;
    logic [IDX_W-1:0] ab_reg, ab_next;
    logic [IDX_W-1:0] lb_reg, lb_next;
    res_t             rr_reg, rr_next;
    res_t             out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic [CNT_W-1:0] t_eff, w_eff, n_dec, rs_val;
    logic             cfg_wr;

    // Table memory ports: anchor size, successor, wander, last position,
    // removed stack, bucket to instance, instance to bucket (valid on top).
    logic             a_we, s_we, w_we, l_we, r_we, bi_we, ib_we;
    logic [AW-1:0]    a_wa, s_wa, w_wa, l_wa, r_wa, bi_wa, ib_wa;
    logic [AW-1:0]    a_ra, s_ra, w_ra, l_ra, r_ra, bi_ra, ib_ra;
    logic [IDX_W-1:0] a_wd, s_wd, w_wd, l_wd, r_wd, bi_wd;
    logic [IDX_W-1:0] a_rd, s_rd, w_rd, l_rd, r_rd, bi_rd;
    logic [CNT_W-1:0] ib_wd, ib_rd;

    mix_ctrl_t        mix_ctrl;
    mod_ctrl_t        mod_ctrl;
    logic [31:0]      mix_d;
    logic             mod_done;
    logic [IDX_W-1:0] mod_rem;

    ach_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_anchor (
        .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
    ach_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_succ (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
    ach_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_wander (
        .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));
    ach_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_lastpos (
        .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
    ach_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_stack (
        .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
    ach_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_b2i (
        .clk(clk), .we(bi_we), .waddr(bi_wa), .wdata(bi_wd), .raddr(bi_ra), .rdata(bi_rd));
    ach_ram #(.WIDTH(CNT_W), .DEPTH(CAPACITY)) u_i2b (
        .clk(clk), .we(ib_we), .waddr(ib_wa), .wdata(ib_wd), .raddr(ib_ra), .rdata(ib_rd));

    ach_mixer u_mixer (
        .clk(clk), .rst_n(rst_n), .ctrl(mix_ctrl), .seed(req_reg.key[63:32] ^ req_reg.key[31:0]),
        .d_out(mix_d));

    ach_mod u_mod (
        .clk(clk), .rst_n(rst_n), .ctrl(mod_ctrl), .done(mod_done), .rem(mod_rem));

    // Effective bucket and working counts after clamping.
    always_comb
    begin
        if (total_reg == '0)
        begin
            t_eff = CNT_W'(1);
        end
        else if (total_reg > CNT_W'(CAPACITY))
        begin
            t_eff = CNT_W'(CAPACITY);
        end
        else
        begin
            t_eff = total_reg;
        end
        w_eff  = (work_reg > t_eff) ? t_eff : work_reg;
        rs_val = t_eff - CNT_W'(1) - {1'b0, clr_reg};
        n_dec  = wc_reg - CNT_W'(1);
    end

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WORKING) ? {21'b0, work_reg} : {21'b0, total_reg};

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        work_next      = work_reg;
        sc_next        = sc_reg;
        wc_next        = wc_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        req_next       = req_reg;
        b_next         = b_reg;
        h_next         = h_reg;
        ab_next        = ab_reg;
        lb_next        = lb_reg;
        rr_next        = rr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        {a_we, s_we, w_we, l_we, r_we, bi_we, ib_we} = '0;
        {a_wa, s_wa, w_wa, l_wa, r_wa, bi_wa, ib_wa} = '0;
        {a_ra, s_ra, w_ra, l_ra, r_ra, bi_ra, ib_ra} = '0;
        {a_wd, s_wd, w_wd, l_wd, r_wd, bi_wd}        = '0;
        ib_wd    = '0;
        mix_ctrl = '0;
        mod_ctrl = '0;
        mod_ctrl.dividend = mix_d;
        mod_ctrl.divisor  = first_reg ? t_eff : {1'b0, ab_reg};

        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // One entry of every table per cycle.
                {a_we, s_we, w_we, l_we, r_we, bi_we, ib_we} = '1;
                {a_wa, s_wa, w_wa, l_wa, r_wa, bi_wa, ib_wa} = {7{clr_reg}};
                a_wd  = ({1'b0, clr_reg} >= w_eff && {1'b0, clr_reg} < t_eff) ? clr_reg : '0;
                s_wd  = clr_reg;
                w_wd  = clr_reg;
                l_wd  = clr_reg;
                bi_wd = clr_reg;
                r_wd  = rs_val[IDX_W-1:0];
                ib_wd = {({1'b0, clr_reg} < w_eff), clr_reg};
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(CAPACITY - 1))
                begin
                    sc_next    = t_eff - w_eff;
                    wc_next    = w_eff;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                rr_next = '0;
                unique case (req_reg.func) inside
                    FUNC_LOOKUP:
                    begin
                        if (wc_reg == '0)
                        begin
                            rr_next.status = STAT_INACTIVE;
                            state_next     = ST_DONE;
                        end
                        else
                        begin
                            mix_ctrl.load = 1'b1;
                            cnt_next      = '0;
                            state_next    = ST_LK_MIX;
                        end
                    end
                    FUNC_ADD, FUNC_REMOVE:
                    begin
                        if ({1'b0, req_reg.inst_id} >= t_eff)
                        begin
                            rr_next.status = STAT_RANGE;
                            state_next     = ST_DONE;
                        end
                        else
                        begin
                            ib_ra = req_reg.inst_id;
                            r_ra  = AW'(sc_reg - CNT_W'(1));
                            w_ra  = wc_reg[AW-1:0];
                            state_next = (req_reg.func == FUNC_ADD) ? ST_AD_CHK : ST_RM_CHK;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_LK_MIX:
            begin
                mix_ctrl.step = 1'b1;
                cnt_next      = cnt_reg + 2'd1;
                if (cnt_reg == 2'(MIX_INIT_ROUNDS - 1))
                begin
                    first_next = 1'b1;
                    state_next = ST_LK_MODGO;
                end
            end
            ST_LK_MODGO:
            begin
                mod_ctrl.start = 1'b1;
                state_next     = ST_LK_MOD;
            end
            ST_LK_MOD:
            begin
                if (mod_done)
                begin
                    if (first_reg)
                    begin
                        b_next     = mod_rem;
                        a_ra       = mod_rem;
                        state_next = ST_LK_CHKA;
                    end
                    else
                    begin
                        h_next     = mod_rem;
                        a_ra       = mod_rem;
                        state_next = ST_LK_CHKH;
                    end
                end
            end
            ST_LK_CHKA:
            begin
                ab_next = a_rd;
                if (a_rd == '0)
                begin
                    bi_ra      = b_reg;
                    state_next = ST_LK_INST;
                end
                else
                begin
                    state_next = ST_LK_STEP;
                end
            end
            ST_LK_STEP:
            begin
                mix_ctrl.step = 1'b1;
                first_next    = 1'b0;
                state_next    = ST_LK_MODGO;
            end
            ST_LK_RDH:
            begin
                a_ra       = h_reg;
                state_next = ST_LK_CHKH;
            end
            ST_LK_CHKH:
            begin
                if (a_rd >= ab_reg)
                begin
                    s_ra       = h_reg;
                    state_next = ST_LK_SUCC;
                end
                else
                begin
                    // Reached a bucket removed later than b, or a working one.
                    b_next  = h_reg;
                    ab_next = a_rd;
                    if (a_rd == '0)
                    begin
                        bi_ra      = h_reg;
                        state_next = ST_LK_INST;
                    end
                    else
                    begin
                        state_next = ST_LK_STEP;
                    end
                end
            end
            ST_LK_SUCC:
            begin
                h_next     = s_rd;
                state_next = ST_LK_RDH;
            end
            ST_LK_INST:
            begin
                rr_next.instance_res = bi_rd;
                rr_next.bucket       = b_reg;
                rr_next.status       = STAT_OK;
                state_next           = ST_DONE;
            end
            ST_AD_CHK:
            begin
                if (ib_rd[CNT_W-1] || sc_reg == '0)
                begin
                    rr_next.status = STAT_NO_FREE;
                    state_next     = ST_DONE;
                end
                else
                begin
                    b_next = r_rd;
                    a_we   = 1'b1;
                    a_wa   = r_rd;
                    a_wd   = '0;
                    l_we   = 1'b1;
                    l_wa   = w_rd;
                    l_wd   = wc_reg[IDX_W-1:0];
                    s_we   = 1'b1;
                    s_wa   = r_rd;
                    s_wd   = r_rd;
                    bi_we  = 1'b1;
                    bi_wa  = r_rd;
                    bi_wd  = req_reg.inst_id;
                    ib_we  = 1'b1;
                    ib_wa  = req_reg.inst_id;
                    ib_wd  = {1'b1, r_rd};
                    sc_next    = sc_reg - CNT_W'(1);
                    wc_next    = wc_reg + CNT_W'(1);
                    state_next = ST_AD_WRW;
                end
            end
            ST_AD_WRW:
            begin
                // Last position is read after its update above.
                l_ra       = b_reg;
                state_next = ST_AD_FIN;
            end
            ST_AD_FIN:
            begin
                w_we = 1'b1;
                w_wa = l_rd;
                w_wd = b_reg;
                rr_next.instance_res = req_reg.inst_id;
                rr_next.bucket       = b_reg;
                rr_next.status       = STAT_OK;
                state_next           = ST_DONE;
            end
            ST_RM_CHK:
            begin
                if (!ib_rd[CNT_W-1] || wc_reg == '0)
                begin
                    rr_next.status = STAT_INACTIVE;
                    state_next     = ST_DONE;
                end
                else
                begin
                    b_next     = ib_rd[IDX_W-1:0];
                    w_ra       = n_dec[AW-1:0];
                    l_ra       = ib_rd[IDX_W-1:0];
                    state_next = ST_RM_WR;
                end
            end
            ST_RM_WR:
            begin
                lb_next = l_rd;
                r_we    = 1'b1;
                r_wa    = sc_reg[AW-1:0];
                r_wd    = b_reg;
                a_we    = 1'b1;
                a_wa    = b_reg;
                a_wd    = n_dec[IDX_W-1:0];
                s_we    = 1'b1;
                s_wa    = b_reg;
                s_wd    = w_rd;
                w_we    = 1'b1;
                w_wa    = l_rd;
                w_wd    = w_rd;
                ib_we   = 1'b1;
                ib_wa   = req_reg.inst_id;
                ib_wd   = {1'b0, b_reg};
                sc_next    = sc_reg + CNT_W'(1);
                wc_next    = n_dec;
                state_next = ST_RM_RD3;
            end
            ST_RM_RD3:
            begin
                w_ra       = wc_reg[AW-1:0];
                state_next = ST_RM_WR2;
            end
            ST_RM_WR2:
            begin
                l_we = 1'b1;
                l_wa = w_rd;
                l_wd = lb_reg;
                rr_next.instance_res = req_reg.inst_id;
                rr_next.bucket       = b_reg;
                rr_next.status       = STAT_OK;
                state_next           = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_next       = rr_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // A register write restarts the clearing pass.
        if (cfg_wr)
        begin
            if (paddr[2] == REG_WORKING)
            begin
                work_next = pwdata[CNT_W-1:0];
            end
            else
            begin
                total_next = pwdata[CNT_W-1:0];
            end
            clr_next   = '0;
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            total_reg     <= CNT_W'(CAPACITY);
            work_reg      <= CNT_W'(CAPACITY);
            sc_reg        <= '0;
            wc_reg        <= '0;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            work_reg      <= work_next;
            sc_reg        <= sc_next;
            wc_reg        <= wc_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        b_reg   <= b_next;
        h_reg   <= h_next;
        ab_reg  <= ab_next;
        lb_reg  <= lb_next;
        rr_reg  <= rr_next;
        out_reg <= out_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Every bucket is either working or on the removed stack.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ({1'b0, wc_reg} + {1'b0, sc_reg} == {1'b0, t_eff}))
        else $error("working and stack counts do not add up to the bucket count");

    // An error result carries zero instance and bucket fields.
    a_errzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status != STAT_OK) |-> (res.bucket == '0 && res.instance_res == '0))
        else $error("error result with nonzero fields");

    // The remainder unit only finishes while a lookup waits for it or while the tables are cleared.
    a_moddone: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_LK_MOD || state_reg == ST_CLEAR))
        else $error("remainder finished outside a lookup");
endmodule
